/* hw/rtl/kvn_pkg.sv */
// ----------------------------------------------------------------------------
// kvn_pkg: shared types and constants for the knob velocity nudge block
// Pin pair codes, detent direction codes, register indexes and the control
// word passed from the decoders to the velocity accumulator.
// ----------------------------------------------------------------------------
package kvn_pkg;

  localparam int VELOCITY_BITS_DEF = 16;

  localparam int STEP_W  = 15;
  localparam int LIMIT_W = 15;
  localparam int DEB_W   = 8;
  localparam int CNT_W   = 9;
  localparam int OUT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // pin pair is {A, B}
  localparam logic [1:0] PINS_00 = 2'b00;
  localparam logic [1:0] PINS_01 = 2'b01;
  localparam logic [1:0] PINS_11 = 2'b11;
  localparam logic [1:0] PINS_10 = 2'b10;

  // detent direction, 2-bit signed
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_UP   = 2'sb01;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;

  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_RST  = 15'd512;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd5120;
  localparam logic [DEB_W-1:0]   DEB_RST   = 8'd20;

  localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

  typedef struct packed {
    logic signed [1:0] dir;
    logic              press;
  } kvn_ctrl_t;

endpackage

/* hw/rtl/kvn_quad.sv */
// ----------------------------------------------------------------------------
// kvn_quad: quadrature detent decoder
// Keeps the previous pin pair and flags the four detent transitions.
// ----------------------------------------------------------------------------
module kvn_quad
  import kvn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              pin_a,
  input  logic              pin_b,
  output logic signed [1:0] dir
);

  logic [1:0] prev_pins_r, prev_pins_nxt;
  logic       primed_r, primed_nxt;
  logic [1:0] now_pins;

  assign now_pins = {pin_a, pin_b};

  always_comb begin
    dir = DIR_NONE;
    if (primed_r) begin
      if ((prev_pins_r == PINS_00 && now_pins == PINS_01) ||
          (prev_pins_r == PINS_11 && now_pins == PINS_10)) begin
        dir = DIR_UP;
      end else if ((prev_pins_r == PINS_01 && now_pins == PINS_00) ||
                   (prev_pins_r == PINS_10 && now_pins == PINS_11)) begin
        dir = DIR_DOWN;
      end
    end
    prev_pins_nxt = en ? now_pins : prev_pins_r;
    primed_nxt    = primed_r | en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r <= PINS_00;
      primed_r    <= 1'b0;
    end else begin
      prev_pins_r <= prev_pins_nxt;
      primed_r    <= primed_nxt;
    end
  end

endmodule

/* hw/rtl/kvn_debounce.sv */
// ----------------------------------------------------------------------------
// kvn_debounce: button debouncer
// Counts milliseconds since the last level change; a level that outlasts
// the debounce time and differs from the stable level is taken.
// ----------------------------------------------------------------------------
module kvn_debounce
  import kvn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             pin_button,
  input  logic             ms_tick,
  input  logic [DEB_W-1:0] debounce_ms,
  output logic             press
);

  logic             last_lvl_r, last_lvl_nxt;
  logic             stable_lvl_r, stable_lvl_nxt;
  logic [CNT_W-1:0] ms_cnt_r, ms_cnt_nxt;
  logic [CNT_W-1:0] cnt_new;
  logic             take;

  always_comb begin
    if (pin_button != last_lvl_r) begin
      cnt_new = '0;
    end else if (ms_tick && ms_cnt_r != CNT_MAX) begin
      cnt_new = ms_cnt_r + 1'b1;
    end else begin
      cnt_new = ms_cnt_r;
    end
    take  = (cnt_new > {1'b0, debounce_ms}) && (pin_button != stable_lvl_r);
    press = take && !pin_button;

    last_lvl_nxt   = en ? pin_button : last_lvl_r;
    ms_cnt_nxt     = en ? cnt_new : ms_cnt_r;
    stable_lvl_nxt = (en && take) ? pin_button : stable_lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lvl_r   <= 1'b1;
      stable_lvl_r <= 1'b1;
      ms_cnt_r     <= '0;
    end else begin
      last_lvl_r   <= last_lvl_nxt;
      stable_lvl_r <= stable_lvl_nxt;
      ms_cnt_r     <= ms_cnt_nxt;
    end
  end

endmodule

/* hw/rtl/kvn_velocity.sv */
// ----------------------------------------------------------------------------
// kvn_velocity: velocity accumulator
// Adds or subtracts the step on a detent, clamps to the limit and to the
// register range, then zeroes on a press.
// ----------------------------------------------------------------------------
module kvn_velocity
  import kvn_pkg::*;
#(
  parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  kvn_ctrl_t          ctrl,
  input  logic [STEP_W-1:0]  velocity_step,
  input  logic [LIMIT_W-1:0] velocity_limit,
  output logic [OUT_W-1:0]   target_velocity
);

  localparam int W = ((VELOCITY_BITS > OUT_W) ? VELOCITY_BITS : OUT_W) + 2;
  localparam logic signed [W-1:0] VMAX =
    {{(W-VELOCITY_BITS+1){1'b0}}, {(VELOCITY_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = ~VMAX;

  logic signed [VELOCITY_BITS-1:0] vel_r, vel_nxt;
  logic signed [W-1:0] vel_ext, step_ext, lim_pos, lim_neg;
  logic signed [W-1:0] sum, clamped, result;

  always_comb begin
    vel_ext  = W'(vel_r);
    step_ext = W'($signed({1'b0, velocity_step}));
    lim_pos  = W'($signed({1'b0, velocity_limit}));
    lim_neg  = -lim_pos;

    sum = (ctrl.dir == DIR_UP) ? vel_ext + step_ext : vel_ext - step_ext;
    clamped = sum;
    if (clamped > lim_pos) clamped = lim_pos;
    if (clamped < lim_neg) clamped = lim_neg;
    if (clamped > VMAX)    clamped = VMAX;
    if (clamped < VMIN)    clamped = VMIN;

    result = (ctrl.dir != DIR_NONE) ? clamped : vel_ext;
    if (ctrl.press) result = '0;

    target_velocity = result[OUT_W-1:0];
    vel_nxt = en ? result[VELOCITY_BITS-1:0] : vel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
    end else begin
      vel_r <= vel_nxt;
    end
  end

endmodule

/* hw/rtl/knob_velocity_nudge.sv */
// ----------------------------------------------------------------------------
// knob_velocity_nudge: quadrature knob and debounced button velocity control
// Turns rotary knob detents into signed Q8.8 velocity steps; a debounced
// button press zeroes the velocity.
// ----------------------------------------------------------------------------
// Takes one sample word per clock and gives one result word per sample. The
// result shows on out_* in the cycle after the sample is accepted, held in
// an output register; in_stall rises only while that register is full and
// out_stall is high, so with out_stall low the block runs at one word per
// cycle. The velocity add and clamp are combinational, between the state
// registers and the output register. Configuration writes are always taken
// (cfg_ready is tied high); indexes past the register list are ignored.
module knob_velocity_nudge
  import kvn_pkg::*;
#(
  parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_pin_a,
  input  logic                    in_pin_b,
  input  logic                    in_pin_button,
  input  logic                    in_ms_tick,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_target_velocity,
  output logic signed [1:0]       out_detent_dir,
  output logic                    out_button_press,
  output logic                    out_command_valid,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic               in_acc;
  kvn_ctrl_t          ctrl;
  logic signed [1:0]  quad_dir;
  logic               btn_press;
  logic [OUT_W-1:0]   vel_out;

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [DEB_W-1:0]   deb_r, deb_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   vel_r;
  logic signed [1:0]  dir_r;
  logic               press_r;
  logic               cmd_r;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    step_nxt  = step_r;
    limit_nxt = limit_r;
    deb_nxt   = deb_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VELOCITY_STEP:  step_nxt  = cfg_data[STEP_W-1:0];
        REG_VELOCITY_LIMIT: limit_nxt = cfg_data[LIMIT_W-1:0];
        REG_DEBOUNCE_MS:    deb_nxt   = cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RST;
      limit_r <= LIMIT_RST;
      deb_r   <= DEB_RST;
    end else begin
      step_r  <= step_nxt;
      limit_r <= limit_nxt;
      deb_r   <= deb_nxt;
    end
  end

  kvn_quad u_quad (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_acc),
    .pin_a (in_pin_a),
    .pin_b (in_pin_b),
    .dir   (quad_dir)
  );

  kvn_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (in_acc),
    .pin_button  (in_pin_button),
    .ms_tick     (in_ms_tick),
    .debounce_ms (deb_r),
    .press       (btn_press)
  );

  assign ctrl = {quad_dir, btn_press};

  kvn_velocity #(
    .VELOCITY_BITS (VELOCITY_BITS)
  ) u_velocity (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (in_acc),
    .ctrl            (ctrl),
    .velocity_step   (step_r),
    .velocity_limit  (limit_r),
    .target_velocity (vel_out)
  );

  // output register
  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vel_r   <= vel_out;
      dir_r   <= ctrl.dir;
      press_r <= ctrl.press;
      cmd_r   <= (ctrl.dir != DIR_NONE) || ctrl.press;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_target_velocity = $signed(vel_r);
  assign out_detent_dir      = dir_r;
  assign out_button_press    = press_r;
  assign out_command_valid   = cmd_r;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for knob_velocity_nudge
// Feeds quadrature knob walks, button bounce and ms ticks through the sample
// channel, predicts every result word in the bench and compares it field by
// field, under random idling on both sides and several register settings.
// ----------------------------------------------------------------------------
module tb;
  import kvn_pkg::*;

  localparam int RX_HOLD_CYCLES = 150;
  localparam int RUN_LIMIT      = 3000000;

  typedef struct packed {
    logic a;
    logic b;
    logic btn;
    logic tick;
  } knob_sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] velocity;
    logic signed [1:0]       dir;
    logic                    press;
    logic                    cmd;
  } nudge_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_pin_a = 1'b0;
  logic in_pin_b = 1'b0;
  logic in_pin_button = 1'b1;
  logic in_ms_tick = 1'b0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_target_velocity;
  logic signed [1:0] out_detent_dir;
  logic out_button_press;
  logic out_command_valid;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  knob_velocity_nudge dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pin_a           (in_pin_a),
    .in_pin_b           (in_pin_b),
    .in_pin_button      (in_pin_button),
    .in_ms_tick         (in_ms_tick),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_velocity(out_target_velocity),
    .out_detent_dir     (out_detent_dir),
    .out_button_press   (out_button_press),
    .out_command_valid  (out_command_valid),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // samples waiting to be sent and result words waiting to arrive
  knob_sample_t  sample_queue[$];
  nudge_result_t velocity_expect[$];
  int n_queued = 0;
  int n_sent = 0;
  int n_accepted = 0;
  int n_cfg_writes = 0;
  int n_mismatch = 0;

  // idling knobs, set by the sequence process
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int tx_wait = 0;
  int rx_wait = 0;

  // predictor copy of registers and state
  int          m_step = int'(STEP_RST);
  int          m_limit = int'(LIMIT_RST);
  int          m_debounce = int'(DEB_RST);
  logic [1:0]  m_prev_pins = PINS_00;
  logic        m_primed = 1'b0;
  logic        m_btn_last = 1'b1;
  logic        m_btn_stable = 1'b1;
  int          m_ms_count = 0;
  longint      m_velocity = 0;

  // knob walk state used by the stimulus
  int   knob_pos = 0;
  logic btn_level = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic nudge_result_t nudge_predict(knob_sample_t s);
    nudge_result_t r;
    logic [1:0] now;
    longint v;
    longint vmax;
    now = {s.a, s.b};
    r.dir = DIR_NONE;
    r.press = 1'b0;
    r.cmd = 1'b0;
    if (m_primed) begin
      if ((m_prev_pins == PINS_00 && now == PINS_01) ||
          (m_prev_pins == PINS_11 && now == PINS_10))
        r.dir = DIR_UP;
      if ((m_prev_pins == PINS_01 && now == PINS_00) ||
          (m_prev_pins == PINS_10 && now == PINS_11))
        r.dir = DIR_DOWN;
    end
    m_prev_pins = now;
    m_primed = 1'b1;

    if (r.dir != DIR_NONE) begin
      vmax = (longint'(1) << (VELOCITY_BITS_DEF - 1)) - 1;
      v = (r.dir == DIR_UP) ? m_velocity + longint'(m_step) : m_velocity - longint'(m_step);
      if (v > longint'(m_limit)) v = longint'(m_limit);
      if (v < -longint'(m_limit)) v = -longint'(m_limit);
      if (v > vmax) v = vmax;
      if (v < -vmax - 1) v = -vmax - 1;
      m_velocity = v;
      r.cmd = 1'b1;
    end

    // a level change restarts the count and eats that item's tick
    if (s.btn != m_btn_last) begin
      m_btn_last = s.btn;
      m_ms_count = 0;
    end else if (s.tick && m_ms_count < int'(CNT_MAX)) begin
      m_ms_count++;
    end
    if (m_ms_count > m_debounce && s.btn != m_btn_stable) begin
      m_btn_stable = s.btn;
      if (!s.btn) begin
        r.press = 1'b1;
        r.cmd = 1'b1;
        m_velocity = 0;
      end
    end
    r.velocity = m_velocity[OUT_W-1:0];
    return r;
  endfunction

  // result checker, register shadow and predictor, all on the rising edge
  always @(posedge clk) begin
    nudge_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VELOCITY_STEP:  m_step = int'(cfg_data[STEP_W-1:0]);
          REG_VELOCITY_LIMIT: m_limit = int'(cfg_data[LIMIT_W-1:0]);
          REG_DEBOUNCE_MS:    m_debounce = int'(cfg_data[DEB_W-1:0]);
          default: ;
        endcase
        n_cfg_writes <= n_cfg_writes + 1;
      end

      if (out_valid && !out_stall) begin
        if (velocity_expect.size() == 0) begin
          $error("result word with no sample pending");
          n_mismatch++;
        end else begin
          want = velocity_expect.pop_front();
          if (out_target_velocity !== want.velocity) begin
            $error("target_velocity: expected %0d, got %0d", want.velocity,
                   out_target_velocity);
            n_mismatch++;
          end
          if (out_detent_dir !== want.dir) begin
            $error("detent_dir: expected %0d, got %0d", want.dir, out_detent_dir);
            n_mismatch++;
          end
          if (out_button_press !== want.press) begin
            $error("button_press: expected %0b, got %0b", want.press, out_button_press);
            n_mismatch++;
          end
          if (out_command_valid !== want.cmd) begin
            $error("command_valid: expected %0b, got %0b", want.cmd, out_command_valid);
            n_mismatch++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        velocity_expect.push_back(nudge_predict({in_pin_a, in_pin_b, in_pin_button,
                                                 in_ms_tick}));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    knob_sample_t s;
    if (in_valid && n_accepted != n_sent) begin
      // word still stalled, hold it
    end else if (tx_wait > 0) begin
      tx_wait <= tx_wait - 1;
      in_valid <= 1'b0;
    end else if (rst_n && sample_queue.size() > 0) begin
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        tx_wait <= idle_len() - 1;
        in_valid <= 1'b0;
      end else begin
        s = sample_queue.pop_front();
        in_pin_a <= s.a;
        in_pin_b <= s.b;
        in_pin_button <= s.btn;
        in_ms_tick <= s.tick;
        in_valid <= 1'b1;
        n_sent <= n_sent + 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result-side stall
  always @(negedge clk) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_wait <= RX_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_wait <= idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void queue_sample(logic [1:0] pins, logic btn, logic tick);
    sample_queue.push_back({pins[1], pins[0], btn, tick});
    n_queued++;
  endfunction

  function automatic logic [1:0] gray_pins(int pos);
    case (pos)
      0: return PINS_00;
      1: return PINS_01;
      2: return PINS_11;
      default: return PINS_10;
    endcase
  endfunction

  // mostly legal gray-code steps either way, some jumps and held positions
  function automatic void queue_walk(int n, int tick_pct, int flip_pct, int jump_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < jump_pct) knob_pos = (knob_pos + 2) % 4;
      else if (r < jump_pct + 40) knob_pos = (knob_pos + 1) % 4;
      else if (r < jump_pct + 80) knob_pos = (knob_pos + 3) % 4;
      if ($urandom_range(0, 99) < flip_pct) btn_level = ~btn_level;
      queue_sample(gray_pins(knob_pos), btn_level, $urandom_range(0, 99) < tick_pct);
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int seen;
    @(negedge clk);
    seen = n_cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (n_cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_knob_regs(int step, int limit, int deb);
    write_reg(REG_VELOCITY_STEP, CFG_DATA_W'(step));
    write_reg(REG_VELOCITY_LIMIT, CFG_DATA_W'(limit));
    // upper data bits are don't-care for the debounce register
    write_reg(REG_DEBOUNCE_MS, {7'($urandom), DEB_W'(deb)});
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sample_queue.size() > 0 || n_accepted != n_queued || velocity_expect.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int n, int tx_pct, int rx_pct, int tick_pct, int flip_pct,
                           int jump_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    queue_walk(n, tick_pct, flip_pct, jump_pct);
    wait_drained();
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values; first sample only primes the pin history
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    queue_sample(PINS_01, 1'b1, 1'b0);
    queue_sample(PINS_00, 1'b1, 1'b1);
    queue_sample(PINS_01, 1'b1, 1'b0);
    queue_sample(PINS_11, 1'b1, 1'b1);
    queue_sample(PINS_10, 1'b1, 1'b0);
    queue_sample(PINS_11, 1'b1, 1'b0);
    queue_sample(PINS_00, 1'b1, 1'b1);
    queue_sample(PINS_11, 1'b1, 1'b0);
    wait_drained();

    // out-of-range index must be ignored; then full-scale step and limit
    write_reg(2'd3, '1);
    set_knob_regs(32767, 32767, 0);
    queue_sample(PINS_10, 1'b1, 1'b0);
    queue_sample(PINS_00, 1'b1, 1'b1);
    queue_sample(PINS_01, 1'b1, 1'b0);
    queue_sample(PINS_00, 1'b1, 1'b0);
    queue_sample(PINS_10, 1'b1, 1'b0);
    queue_sample(PINS_11, 1'b1, 1'b0);
    queue_sample(PINS_01, 1'b1, 1'b0);
    queue_sample(PINS_00, 1'b1, 1'b0);
    queue_sample(PINS_00, 1'b0, 1'b1);
    queue_sample(PINS_00, 1'b0, 1'b1);
    queue_sample(PINS_01, 1'b0, 1'b1);
    queue_sample(PINS_11, 1'b1, 1'b1);
    queue_sample(PINS_10, 1'b1, 1'b1);
    queue_sample(PINS_10, 1'b0, 1'b0);
    queue_sample(PINS_11, 1'b0, 1'b1);
    queue_sample(PINS_10, 1'b0, 1'b0);
    queue_sample(PINS_11, 1'b0, 1'b1);
    queue_sample(PINS_10, 1'b1, 1'b1);
    wait_drained();
    knob_pos = 3;
    btn_level = 1'b1;

    set_knob_regs(int'(STEP_RST), int'(LIMIT_RST), int'(DEB_RST));
    run_phase(120, 30, 30, 50, 2, 10);

    set_knob_regs($urandom_range(1, 2000), $urandom_range(0, 8000), $urandom_range(0, 10));
    run_phase(100, 20, 50, 70, 10, 10);

    set_knob_regs(0, 32767, 3);
    run_phase(60, 40, 10, 60, 8, 15);

    // receiver holds off while the sender keeps offering words
    set_knob_regs(300, 20000, 2);
    tx_idle_pct = 0;
    rx_idle_pct = 10;
    rx_hold_req++;
    queue_walk(120, 50, 3, 5);
    wait_drained();

    // lowered limit: velocity may sit above it until the next detent
    set_knob_regs(1, 100, 255);
    run_phase(80, 20, 20, 50, 0, 10);

    // long steady button with a tick every sample saturates the ms count
    set_knob_regs(32767, 0, 255);
    run_phase(540, 0, 0, 100, 0, 5);

    set_knob_regs($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 255));
    run_phase(40, 40, 40, 30, 5, 10);

    repeat (10) @(negedge clk);
    if (n_mismatch == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
